/* hw/rtl/reb_pkg.sv */
// ----------------------------------------------------------------------------
// reb_pkg
// Shared types and codes for the rotary encoder and button event block.
// ----------------------------------------------------------------------------
package reb_pkg;

  localparam int NOW_BITS  = 32;
  localparam int STEPS_OUT = 8;
  localparam int DEB_BITS  = 16;

  typedef struct packed {
    logic                line_a;
    logic                line_b;
    logic                button_line;
    logic                poll;
    logic [NOW_BITS-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic                        event_kind;
    logic signed [STEPS_OUT-1:0] rotation_steps;
  } out_item_t;

  // Turn report from the encoder counter to the top level.
  typedef struct packed {
    logic                        hit;
    logic signed [STEPS_OUT-1:0] steps;
  } reb_turn_t;

  localparam logic EV_TURN  = 1'b0;
  localparam logic EV_CLICK = 1'b1;

endpackage

/* hw/rtl/rotary_encoder_button_events.sv */
// ----------------------------------------------------------------------------
// rotary_encoder_button_events
// Rotary encoder decoder with debounced push-button click events.
// ----------------------------------------------------------------------------
// Takes one sample item per clock while results drain and gives at most
// one event item for it, held first in the input register and then in the
// result register. The input register and the result register each hold one
// item, so a new sample is taken in every cycle as long as out_ready keeps
// draining results; a stalled result holds the input register and only then
// drops in_ready. A falling edge on line A moves a saturating signed step
// count (up with B high, down with B low). On a poll, a nonzero count is
// reported as a turn event (event_kind 0) and cleared; with a zero count the
// button state machine runs and reports a click (event_kind 1, zero steps)
// once the button has stayed released for debounce_time milliseconds. Write
// debounce_time through cfg_we/cfg_wdata only while no item is in flight.
// ----------------------------------------------------------------------------
module rotary_encoder_button_events
  import reb_pkg::*;
#(
  parameter int TIME_BITS = 32,
  parameter int STEP_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [DEB_BITS-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data
);

  logic [DEB_BITS-1:0] debounce_r;
  logic                in_valid_r;
  in_item_t            in_data_r;
  logic                out_valid_r;
  logic                out_valid_nxt;
  out_item_t           out_data_r;
  out_item_t           out_data_nxt;
  logic                adv;
  logic                fire;
  logic                btn_en;
  logic                click;
  reb_turn_t           turn;

  // Advance the held sample when the result register is free or draining.
  assign adv      = !out_valid_r || out_ready;
  assign fire     = in_valid_r && adv;
  assign in_ready = !in_valid_r || adv;

  // The button only runs on a poll that leaves no turn to report.
  assign btn_en = fire && in_data_r.poll && !turn.hit;

  reb_encoder #(
    .STEP_BITS (STEP_BITS)
  ) u_encoder (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .line_a (in_data_r.line_a),
    .line_b (in_data_r.line_b),
    .poll   (in_data_r.poll),
    .turn   (turn)
  );

  reb_button #(
    .TIME_BITS (TIME_BITS)
  ) u_button (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (btn_en),
    .button_line   (in_data_r.button_line),
    .now_ms        (in_data_r.now_ms),
    .debounce_time (debounce_r),
    .click         (click)
  );

  always_comb begin
    out_valid_nxt = fire && (turn.hit || click);
    if (turn.hit) begin
      out_data_nxt.event_kind     = EV_TURN;
      out_data_nxt.rotation_steps = turn.steps;
    end else begin
      out_data_nxt.event_kind     = EV_CLICK;
      out_data_nxt.rotation_steps = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= DEB_BITS'(50);
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) debounce_r <= cfg_wdata;
      if (in_ready) in_valid_r <= in_valid;
      if (adv) out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: load on acceptance, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_data_r <= in_data;
    if (adv && out_valid_nxt) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_click_zero_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.event_kind == EV_CLICK |-> out_data_r.rotation_steps == '0)
    else $error("click event carries steps");

  a_turn_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.event_kind == EV_TURN |-> out_data_r.rotation_steps != '0)
    else $error("turn event with zero steps");

  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    !(turn.hit && btn_en))
    else $error("button ran on a sample with a turn report");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready && in_valid_r |=> in_valid_r && $stable(in_data_r))
    else $error("input register changed under a stalled result");

endmodule

/* hw/rtl/reb_encoder.sv */
// ----------------------------------------------------------------------------
// reb_encoder
// Quadrature step counter with saturation and turn report on poll.
// ----------------------------------------------------------------------------
module reb_encoder
  import reb_pkg::*;
#(
  parameter int STEP_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  logic      line_a,
  input  logic      line_b,
  input  logic      poll,
  output reb_turn_t turn
);

  localparam int CW = (STEP_BITS > STEPS_OUT) ? STEP_BITS : STEPS_OUT;
  localparam logic signed [STEP_BITS-1:0] STEP_MAX = {1'b0, {(STEP_BITS-1){1'b1}}};
  localparam logic signed [STEP_BITS-1:0] STEP_MIN = {1'b1, {(STEP_BITS-1){1'b0}}};
  localparam logic signed [CW-1:0] OUT_MAX = CW'(127);
  localparam logic signed [CW-1:0] OUT_MIN = CW'(-128);

  logic                        prev_a_r;
  logic                        prev_a_nxt;
  logic signed [STEP_BITS-1:0] count_r;
  logic signed [STEP_BITS-1:0] count_nxt;
  logic signed [STEP_BITS-1:0] count_upd;
  logic signed [CW-1:0]        count_wide;
  logic signed [CW-1:0]        count_clamp;

  always_comb begin
    count_upd  = count_r;
    prev_a_nxt = prev_a_r;
    if (line_a != prev_a_r) begin
      prev_a_nxt = line_a;
      // falling edge on A: B selects the direction
      if (!line_a) begin
        if (line_b) begin
          if (count_r != STEP_MAX) count_upd = count_r + STEP_BITS'(1);
        end else begin
          if (count_r != STEP_MIN) count_upd = count_r - STEP_BITS'(1);
        end
      end
    end

    count_wide = CW'(count_upd);
    if (count_wide > OUT_MAX) begin
      count_clamp = OUT_MAX;
    end else if (count_wide < OUT_MIN) begin
      count_clamp = OUT_MIN;
    end else begin
      count_clamp = count_wide;
    end

    turn.hit   = poll && (count_upd != '0);
    turn.steps = count_clamp[STEPS_OUT-1:0];
    count_nxt  = turn.hit ? '0 : count_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_r <= 1'b1;
      count_r  <= '0;
    end else if (fire) begin
      prev_a_r <= prev_a_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(count_r) && $stable(prev_a_r))
    else $error("step count moved without an item");

  a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && turn.hit |=> count_r == '0)
    else $error("count not cleared after a turn report");

  a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    turn.hit |-> turn.steps != '0)
    else $error("turn report carries zero steps");

endmodule

/* hw/rtl/reb_button.sv */
// ----------------------------------------------------------------------------
// reb_button
// Button debounce state machine with wrapping time differences.
// ----------------------------------------------------------------------------
module reb_button
  import reb_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                button_line,
  input  logic [NOW_BITS-1:0] now_ms,
  input  logic [DEB_BITS-1:0] debounce_time,
  output logic                click
);

  localparam int TW = (TIME_BITS > NOW_BITS) ? TIME_BITS : NOW_BITS;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_PRESSED  = 2'd2
  } phase_t;

  phase_t                 phase_r;
  phase_t                 phase_nxt;
  logic [TIME_BITS-1:0]   start_r;
  logic [TIME_BITS-1:0]   start_nxt;
  logic [TIME_BITS-1:0]   last_r;
  logic [TIME_BITS-1:0]   last_nxt;
  logic [TW-1:0]          now_w;
  logic [TIME_BITS-1:0]   now_t;
  logic [TIME_BITS-1:0]   deb_t;
  logic                   pressed;
  logic                   start_done;
  logic                   release_done;

  always_comb begin
    now_w        = TW'(now_ms);
    now_t        = now_w[TIME_BITS-1:0];
    deb_t        = TIME_BITS'(debounce_time);
    pressed      = !button_line;
    last_nxt     = pressed ? now_t : last_r;
    start_done   = (now_t - start_r) >= deb_t;
    release_done = (now_t - last_nxt) >= deb_t;
    phase_nxt    = phase_r;
    start_nxt    = start_r;
    click        = 1'b0;
    case (phase_r)
      PH_DEBOUNCE: begin
        if (start_done) phase_nxt = pressed ? PH_PRESSED : PH_IDLE;
      end
      PH_PRESSED: begin
        if (release_done) begin
          phase_nxt = PH_IDLE;
          click     = en;
        end
      end
      default: begin
        // unused encoding falls back to idle
        phase_nxt = PH_IDLE;
        if (pressed) begin
          phase_nxt = PH_DEBOUNCE;
          start_nxt = now_t;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      start_r <= '0;
      last_r  <= '0;
    end else if (en) begin
      phase_r <= phase_nxt;
      start_r <= start_nxt;
      last_r  <= last_nxt;
    end
  end

  a_click_from_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    click |-> phase_r == PH_PRESSED)
    else $error("click outside the pressed phase");

  a_click_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    click |=> phase_r == PH_IDLE)
    else $error("phase not idle after a click");

  a_hold_when_off: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(phase_r) && $stable(start_r) && $stable(last_r))
    else $error("button state moved while not enabled");

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rotary encoder and button event block.
// ----------------------------------------------------------------------------
// Encoder and button samples go in through a valid/ready channel; each
// accepted sample is run through a cycle-free model of the turn counter and
// the button debounce machine, and every event that comes out is matched
// in order against the model's prediction. The run starts with a short set
// of hand-picked samples, then moves through several debounce settings.
// Each setting gets quadrature spins, press/release sequences and random
// noise, and the two long spins drive the count into saturation.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import reb_pkg::*;

  localparam int WATCHDOG_CYCLES = 4000;  // cycles with no handshake at all
  localparam int LONG_HOLD       = 400;   // receiver hold-off that fills the block
  localparam int SETTLE_CYCLES   = 8;     // two-stage pipeline plus margin
  localparam int PHASE_ITEMS     = 130;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_PRESSED  = 2'd2
  } btn_phase_e;

  // --------------------------------------------------------------------------
  // Event tracker: mirrors the block's state and holds the events still due.
  // --------------------------------------------------------------------------
  class event_tracker;
    logic [DEB_BITS-1:0]  debounce_ms;
    logic                 last_a;
    logic signed [7:0]    net_steps;
    btn_phase_e           phase;
    logic [NOW_BITS-1:0]  press_start;
    logic [NOW_BITS-1:0]  last_pressed;
    out_item_t            due_events[$];
    int                   errors;
    int                   turns_seen;
    int                   clicks_seen;

    function new();
      debounce_ms  = 16'd50;
      last_a       = 1'b1;
      net_steps    = 8'sd0;
      phase        = PH_IDLE;
      press_start  = '0;
      last_pressed = '0;
      errors       = 0;
      turns_seen   = 0;
      clicks_seen  = 0;
    endfunction

    function bit held_long(logic [NOW_BITS-1:0] now, logic [NOW_BITS-1:0] since);
      logic [NOW_BITS-1:0] diff;
      diff = now - since;  // wraps modulo 2^32
      return diff >= {16'd0, debounce_ms};
    endfunction

    // Work out what one accepted sample produces and queue it.
    function void predict_sample(in_item_t s);
      out_item_t ev;
      logic      pressed;
      // Count on the falling edge of A; B gives the direction.
      if (s.line_a != last_a) begin
        last_a = s.line_a;
        if (!s.line_a) begin
          if (s.line_b) begin
            if (net_steps != 8'sd127) net_steps = net_steps + 8'sd1;
          end else begin
            if (net_steps != -8'sd128) net_steps = net_steps - 8'sd1;
          end
        end
      end
      if (!s.poll) return;
      // A pending turn wins over the button and blocks it for this poll.
      if (net_steps != 8'sd0) begin
        ev.event_kind     = EV_TURN;
        ev.rotation_steps = net_steps;
        due_events.push_back(ev);
        net_steps = 8'sd0;
        return;
      end
      pressed = !s.button_line;
      if (pressed) last_pressed = s.now_ms;
      case (phase)
        PH_DEBOUNCE: begin
          if (held_long(s.now_ms, press_start)) phase = pressed ? PH_PRESSED : PH_IDLE;
        end
        PH_PRESSED: begin
          if (held_long(s.now_ms, last_pressed)) begin
            phase             = PH_IDLE;
            ev.event_kind     = EV_CLICK;
            ev.rotation_steps = 8'sd0;
            due_events.push_back(ev);
          end
        end
        default: begin
          phase = PH_IDLE;
          if (pressed) begin
            phase       = PH_DEBOUNCE;
            press_start = s.now_ms;
          end
        end
      endcase
    endfunction

    // Compare one delivered event with the oldest one due.
    function void match_event(out_item_t got);
      out_item_t want;
      if (due_events.size() == 0) begin
        $display("%0t: unexpected event: kind %0d steps %0d", $time,
                 got.event_kind, got.rotation_steps);
        errors++;
        return;
      end
      want = due_events.pop_front();
      if (got.event_kind !== want.event_kind) begin
        $display("%0t: event_kind mismatch: expected %0d, got %0d", $time,
                 want.event_kind, got.event_kind);
        errors++;
      end
      if (got.rotation_steps !== want.rotation_steps) begin
        $display("%0t: rotation_steps mismatch: expected %0d, got %0d", $time,
                 want.rotation_steps, got.rotation_steps);
        errors++;
      end
      if (want.event_kind == EV_TURN) turns_seen++;
      else clicks_seen++;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known level.
  // --------------------------------------------------------------------------
  logic                clk;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [DEB_BITS-1:0] cfg_wdata = '0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;

  rotary_encoder_button_events uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  event_tracker        tracker;
  int                  items_sent   = 0;
  int                  burst_left   = 0;
  int                  settings_run = 0;
  int                  holds_done   = 0;
  int                  idle_cycles  = 0;
  bit                  hold_req     = 1'b0;
  logic [NOW_BITS-1:0] stamp        = '0;
  int unsigned         deb_now      = 50;
  logic                a_level      = 1'b1;
  logic                btn_level    = 1'b1;

  // --------------------------------------------------------------------------
  // Monitor: check the outgoing event first, then feed the accepted sample
  // to the tracker, so the order inside one edge never matters.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) tracker.match_event(out_data);
      if (in_valid && in_ready) tracker.predict_sample(in_data);
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: no handshake for %0d cycles, %0d events still due", $time,
               idle_cycles, tracker.due_events.size());
      $display("** rotary_encoder_button_events: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: its own stall pattern, re-chosen at random from four modes, plus
  // one long hold-off on request while the sender keeps offering items.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int cyc;
    int mode;
    cyc  = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end else begin
        if (cyc % 64 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (cyc % 5 != 0);
        endcase
        cyc++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender helpers
  // --------------------------------------------------------------------------
  function in_item_t mk(logic a, logic b, logic btn, logic pl, logic [NOW_BITS-1:0] now);
    in_item_t s;
    s.line_a      = a;
    s.line_b      = b;
    s.button_line = btn;
    s.poll        = pl;
    s.now_ms      = now;
    return s;
  endfunction

  // Advance the millisecond clock by a step scaled to the debounce time;
  // now and then jump right past the debounce window.
  function logic [NOW_BITS-1:0] next_stamp();
    int unsigned inc;
    if ($urandom_range(0, 7) == 0) inc = deb_now + $urandom_range(0, 3);
    else inc = $urandom_range(0, (deb_now == 0) ? 2 : deb_now / 3 + 1);
    stamp = stamp + inc;
    return stamp;
  endfunction

  // Offer one item; bursts of random length with random gaps between them.
  task automatic offer_sample(input in_item_t s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    items_sent++;
  endtask

  // Drop valid and let the block drain before touching the register.
  task automatic set_debounce(input int unsigned ms);
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (tracker.due_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= ms[DEB_BITS-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.debounce_ms = ms[DEB_BITS-1:0];
    deb_now = ms;
    settings_run++;
  endtask

  // Quadrature spin: A high then low each step, B giving the direction.
  // With poll_odds zero nothing polls until the end, so the count builds up.
  task automatic spin(input int n, input logic cw, input int poll_odds);
    logic dir;
    for (int i = 0; i < n; i++) begin
      dir = (poll_odds != 0 && $urandom_range(0, 7) == 0) ? ~cw : cw;
      offer_sample(mk(1'b1, dir, btn_level,
                      poll_odds != 0 && $urandom_range(1, poll_odds) == 1, next_stamp()));
      offer_sample(mk(1'b0, dir, btn_level,
                      poll_odds != 0 && $urandom_range(1, poll_odds) == 1, next_stamp()));
    end
    offer_sample(mk(1'b0, 1'($urandom_range(0, 1)), btn_level, 1'b1, next_stamp()));
    a_level = 1'b0;
  endtask

  // Hold the button for a few samples, then release it for a few more.
  task automatic press_release();
    int hold_n;
    int rel_n;
    hold_n = $urandom_range(1, 8);
    rel_n  = $urandom_range(1, 8);
    repeat (hold_n)
      offer_sample(mk(a_level, 1'($urandom_range(0, 1)), 1'b0,
                      $urandom_range(0, 4) != 0, next_stamp()));
    repeat (rel_n)
      offer_sample(mk(a_level, 1'($urandom_range(0, 1)), 1'b1,
                      $urandom_range(0, 4) != 0, next_stamp()));
    btn_level = 1'b1;
  endtask

  // Anything goes, including stamps from nowhere.
  task automatic noise_sample();
    in_item_t s;
    s = mk(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
           1'($urandom_range(0, 1)), ($urandom_range(0, 1) == 0) ? $urandom : next_stamp());
    a_level   = s.line_a;
    btn_level = s.button_line;
    offer_sample(s);
  endtask

  // --------------------------------------------------------------------------
  // Main stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned deb_plan[6];
    int          phase_start;
    int          pick;
    tracker  = new();
    deb_plan = '{0, 65535, 1, 0, 7, 50};
    deb_plan[3] = $urandom_range(2, 400);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Hand-picked samples at the reset debounce of 50 ms.
    offer_sample(mk(1'b1, 1'b0, 1'b1, 1'b1, 32'd0));            // idle poll, no event
    offer_sample(mk(1'b0, 1'b1, 1'b1, 1'b1, 32'd1));            // turn up
    offer_sample(mk(1'b1, 1'b1, 1'b1, 1'b0, 32'd2));            // rising A, no step
    offer_sample(mk(1'b0, 1'b0, 1'b1, 1'b0, 32'd3));            // step down, no poll
    offer_sample(mk(1'b0, 1'b0, 1'b1, 1'b1, 32'd4));            // turn down
    offer_sample(mk(1'b1, 1'b1, 1'b0, 1'b1, 32'd1000));         // press: start debounce
    offer_sample(mk(1'b1, 1'b1, 1'b0, 1'b1, 32'd1049));         // one short of debounce
    offer_sample(mk(1'b1, 1'b1, 1'b0, 1'b1, 32'd1050));         // now pressed
    offer_sample(mk(1'b1, 1'b1, 1'b0, 1'b0, 32'd1051));         // no poll: button ignored
    offer_sample(mk(1'b1, 1'b1, 1'b1, 1'b1, 32'd1060));         // released, too soon
    offer_sample(mk(1'b1, 1'b1, 1'b1, 1'b1, 32'd1100));         // click
    offer_sample(mk(1'b1, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFF0));    // press just before wrap
    offer_sample(mk(1'b1, 1'b1, 1'b0, 1'b1, 32'h0000_0020));    // 48 ms across the wrap
    offer_sample(mk(1'b0, 1'b1, 1'b0, 1'b1, 32'h0000_0022));    // turn blocks the button
    offer_sample(mk(1'b1, 1'b1, 1'b0, 1'b1, 32'h0000_0022));    // 50 ms: pressed
    offer_sample(mk(1'b1, 1'b1, 1'b1, 1'b1, 32'h0000_0053));    // 49 ms released
    offer_sample(mk(1'b1, 1'b1, 1'b1, 1'b1, 32'h0000_0054));    // click
    offer_sample(mk(1'b1, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF));    // press at the top stamp
    offer_sample(mk(1'b0, 1'b0, 1'b0, 1'b1, 32'h0000_0000));    // turn down while held
    offer_sample(mk(1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF));    // zero elapsed
    offer_sample(mk(1'b1, 1'b1, 1'b1, 1'b1, 32'h7FFF_FFFF));    // released: back to idle
    a_level = 1'b1;

    // Random part, one debounce setting at a time.
    for (int p = 0; p < 6; p++) begin
      set_debounce(deb_plan[p]);
      if (p == 2) hold_req = 1'b1;
      if (p % 2 == 1) stamp = 32'hFFFF_FFFF - $urandom_range(0, 200000);
      else stamp = $urandom;
      // Drive the count into each limit once.
      if (p == 0) spin(140, 1'b1, 0);
      if (p == 1) spin(140, 1'b0, 0);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          press_release();
        end else if (pick < 80) begin
          btn_level = 1'($urandom_range(0, 1));
          spin($urandom_range(1, 12), 1'($urandom_range(0, 1)), 6);
        end else begin
          noise_sample();
        end
      end
    end

    // Drain and settle.
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.due_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d samples over %0d debounce settings, %0d long receiver hold-off(s).",
             items_sent, settings_run + 1, holds_done);
    $display("Matched %0d turn events and %0d clicks; %0d mismatches.",
             tracker.turns_seen, tracker.clicks_seen, tracker.errors);
    if (tracker.errors == 0) begin
      $display("** rotary_encoder_button_events: PASSED **");
    end else begin
      $display("** rotary_encoder_button_events: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/reb_pkg.sv
hw/rtl/reb_encoder.sv
hw/rtl/reb_button.sv
hw/rtl/rotary_encoder_button_events.sv
test/testbench.sv
